>>> rtl/abi_pkg.sv
// ----------------------------------------------------------------------------
// abi_pkg
// Types and constants shared by the ARP binding inspector modules.
// ----------------------------------------------------------------------------
package abi_pkg;

    localparam logic [15:0] OPCODE_REPLY = 16'd2;
    localparam logic [7:0]  CHANGES_MAX  = 8'd255;
    localparam logic [7:0]  MAX_CHANGES_RESET = 8'd3;

    typedef enum logic [2:0] {
        VERDICT_NONE      = 3'd0,
        VERDICT_TRUSTED   = 3'd1,
        VERDICT_CHANGED   = 3'd2,
        VERDICT_LIMIT     = 3'd3,
        VERDICT_OTHER_IP  = 3'd4
    } t_verdict;

    typedef struct packed {
        logic        func;
        logic [15:0] opcode;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
    } t_in_item;

    typedef struct packed {
        logic [2:0] verdict;
        logic       ignored;
        logic       learned;
        logic       table_full;
        logic       block_issued;
        logic       blacklist_full;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_BRD,
        ST_BCHK,
        ST_BWAIT,
        ST_LRD,
        ST_LCHK,
        ST_LWAIT,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch the item
        logic bind_rd;     // issue binding read at index
        logic idx_clr;     // index back to zero
        logic idx_inc;     // advance index
        logic bind_eval;   // evaluate returned binding entry
        logic blk_rd;      // issue blacklist read
        logic blk_eval;    // compare returned blacklist entry
        logic finish;      // commit appends, present result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_load;
        logic is_reply;
        logic bind_end;    // index reached binding count
        logic blk_end;     // index reached blacklist count
        logic hit;         // a rule fired on the entry just evaluated
        logic blk_hit;     // entry just compared matches
    } t_status;

endpackage

>>> rtl/abi_ram.sv
// ----------------------------------------------------------------------------
// abi_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module abi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/abi_ctrl.sv
// ----------------------------------------------------------------------------
// abi_ctrl
// Sequencer: for a reply, walks the binding table, then on a hit the blacklist, one entry at a time.
// ----------------------------------------------------------------------------
module abi_ctrl
    import abi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_start) n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                if (i_status.is_load || !i_status.is_reply) n_state = ST_DONE;
                else if (i_status.bind_end) n_state = ST_DONE;
                else n_state = ST_BRD;
            end
            ST_BRD:   n_state = ST_BWAIT;
            ST_BWAIT: n_state = ST_BCHK;
            ST_BCHK: begin
                if (i_status.hit) n_state = i_status.blk_end ? ST_DONE : ST_LRD;
                else if (i_status.bind_end) n_state = ST_DONE;
                else n_state = ST_BRD;
            end
            ST_LRD:   n_state = ST_LWAIT;
            ST_LWAIT: n_state = ST_LCHK;
            ST_LCHK: begin
                if (i_status.blk_hit || i_status.blk_end) n_state = ST_DONE;
                else n_state = ST_LRD;
            end
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:     begin o_cmd.capture = i_start; o_cmd.idx_clr = 1'b1; end
            ST_BRD:      o_cmd.bind_rd = 1'b1;
            ST_BCHK: begin
                o_cmd.bind_eval = 1'b1;
                if (i_status.hit) o_cmd.idx_clr = 1'b1;
                else o_cmd.idx_inc = 1'b1;
            end
            ST_LRD:      o_cmd.blk_rd = 1'b1;
            ST_LCHK: begin
                o_cmd.blk_eval = 1'b1;
                o_cmd.idx_inc  = 1'b1;
            end
            ST_DONE:     o_cmd.finish = 1'b1;
            default:     o_cmd = '0;
        endcase
    end
endmodule

>>> rtl/abi_datapath.sv
// ----------------------------------------------------------------------------
// abi_datapath
// Item register, binding and blacklist memories, entry compare and counters.
// ----------------------------------------------------------------------------
module abi_datapath
    import abi_pkg::*;
#(
    parameter int TABLE_ENTRIES     = 64,
    parameter int BLACKLIST_ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  logic [7:0] i_max_changes,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    output t_out_item  o_result,
    output logic       o_result_valid
);
    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int BW = (BLACKLIST_ENTRIES > 1) ? $clog2(BLACKLIST_ENTRIES) : 1;
    localparam int TCW = $clog2(TABLE_ENTRIES + 1);
    localparam int BCW = $clog2(BLACKLIST_ENTRIES + 1);
    localparam int CW  = (TCW > BCW) ? TCW : BCW;
    localparam int EW  = 48 + 1 + 8 + 32;
    localparam int TD  = (TABLE_ENTRIES > 1) ? TABLE_ENTRIES : 2;
    localparam int BD  = (BLACKLIST_ENTRIES > 1) ? BLACKLIST_ENTRIES : 2;

    t_in_item        r_item;
    logic [CW-1:0]   r_idx;
    logic [TCW-1:0]  r_bind_count;
    logic [BCW-1:0]  r_blk_count;
    logic [2:0]      r_verdict;
    logic            r_result_valid;
    t_out_item       r_result;

    // binding memory fields: ip, mac, trusted, changes
    logic            b_we;
    logic [TW-1:0]   b_waddr;
    logic [EW-1:0]   b_wdata, b_rdata;
    logic [TW-1:0]   b_hit_addr;
    logic [31:0]     k_rdata;
    logic            k_we;

    logic [31:0] e_ip;
    logic [47:0] e_mac;
    logic        e_trusted;
    logic [7:0]  e_changes;
    assign {e_ip, e_mac, e_trusted, e_changes} = b_rdata;

    logic same_ip, same_mac;
    logic [2:0] entry_verdict;
    assign same_ip  = (e_ip == r_item.sender_ip);
    assign same_mac = (e_mac == r_item.sender_mac);

    always_comb begin
        entry_verdict = VERDICT_NONE;
        if (same_ip && e_trusted && !same_mac) entry_verdict = VERDICT_TRUSTED;
        else if (same_ip && !e_trusted && !same_mac) entry_verdict = VERDICT_CHANGED;
        else if (same_ip && !e_trusted && (e_changes >= i_max_changes))
            entry_verdict = VERDICT_LIMIT;
        else if (same_mac && !same_ip) entry_verdict = VERDICT_OTHER_IP;
    end

    assign b_hit_addr = r_idx[TW-1:0];

    // write port: update on changed MAC, append on finish
    logic append_bind, bind_room, blk_room, verdict_set;
    assign bind_room   = (r_bind_count < TCW'(TABLE_ENTRIES));
    assign blk_room    = (r_blk_count < BCW'(BLACKLIST_ENTRIES));
    assign verdict_set = (r_verdict != VERDICT_NONE);

    logic finish_load, finish_insp, blk_found;
    logic r_blk_found;
    assign finish_load = i_cmd.finish && !r_item.func && (r_item.sender_mac != '0);
    assign finish_insp = i_cmd.finish && r_item.func && (r_item.opcode == OPCODE_REPLY);
    assign append_bind = (finish_load || (finish_insp && !verdict_set)) && bind_room;
    assign blk_found   = r_blk_found;

    always_comb begin
        b_we    = 1'b0;
        b_waddr = r_bind_count[TW-1:0];
        b_wdata = {r_item.sender_ip, r_item.sender_mac, !r_item.func, 8'd0};
        if (i_cmd.bind_eval && entry_verdict == VERDICT_CHANGED) begin
            b_we    = 1'b1;
            b_waddr = b_hit_addr;
            b_wdata = {e_ip, r_item.sender_mac, e_trusted,
                       (e_changes < CHANGES_MAX) ? e_changes + 8'd1 : e_changes};
        end else if (append_bind) begin
            b_we = 1'b1;
        end
    end

    abi_ram #(.WIDTH(EW), .DEPTH(TD)) u_bind_ram (
        .i_clk  (i_clk),
        .i_we   (b_we),
        .i_waddr(b_waddr),
        .i_wdata(b_wdata),
        .i_raddr(r_idx[TW-1:0]),
        .o_rdata(b_rdata)
    );

    assign k_we = finish_insp && verdict_set && !blk_found && blk_room;

    abi_ram #(.WIDTH(32), .DEPTH(BD)) u_blk_ram (
        .i_clk  (i_clk),
        .i_we   (k_we),
        .i_waddr(r_blk_count[BW-1:0]),
        .i_wdata(r_item.sender_ip),
        .i_raddr(r_idx[BW-1:0]),
        .o_rdata(k_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bind_count   <= '0;
            r_blk_count    <= '0;
            r_result_valid <= 1'b0;
            r_idx          <= '0;
        end else begin
            r_result_valid <= i_cmd.finish;
            if (i_cmd.idx_clr) r_idx <= '0;
            else if (i_cmd.idx_inc) r_idx <= r_idx + CW'(1);
            if (append_bind) r_bind_count <= r_bind_count + TCW'(1);
            if (k_we) r_blk_count <= r_blk_count + BCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item      <= i_item;
            r_verdict   <= VERDICT_NONE;
            r_blk_found <= 1'b0;
        end
        if (i_cmd.bind_eval) r_verdict <= entry_verdict;
        if (i_cmd.blk_eval && (k_rdata == r_item.sender_ip)) r_blk_found <= 1'b1;
        if (i_cmd.finish) begin
            r_result.verdict        <= r_item.func ? r_verdict : VERDICT_NONE;
            r_result.ignored        <= r_item.func ? (r_item.opcode != OPCODE_REPLY)
                                                   : (r_item.sender_mac == '0);
            r_result.learned        <= append_bind;
            r_result.table_full     <= finish_load && !bind_room;
            r_result.block_issued   <= finish_insp && verdict_set && !blk_found;
            r_result.blacklist_full <= finish_insp && verdict_set && !blk_found
                                       && !blk_room;
        end
    end

    // The blacklist walk starts from entry zero, so on a clear only an empty list ends it.
    assign o_status.is_load  = !r_item.func;
    assign o_status.is_reply = (r_item.opcode == OPCODE_REPLY);
    assign o_status.bind_end = (CW'(r_bind_count) <= r_idx + CW'(i_cmd.idx_inc));
    assign o_status.blk_end  = i_cmd.idx_clr ? (r_blk_count == '0)
                               : (CW'(r_blk_count) <= r_idx + CW'(i_cmd.idx_inc));
    assign o_status.hit      = (entry_verdict != VERDICT_NONE);
    assign o_status.blk_hit  = (k_rdata == r_item.sender_ip);

    assign o_result       = r_result;
    assign o_result_valid = r_result_valid;
endmodule

>>> rtl/arp_binding_inspector.sv
// ----------------------------------------------------------------------------
// arp_binding_inspector
// Dynamic ARP inspection: binding table search plus blacklist of blocked IPs.
// ----------------------------------------------------------------------------
// Flow: a load or non-reply item goes straight to the finish step; a reply
//   walks the bindings and, once a rule fires, the blacklist.
// Items are handled one at a time: start is taken only while idle, so the pace
//   is set by the serial walk through the binding and blacklist memories.
// Reset clears the counts and sets the change limit to 3; memory contents stay
//   undefined, only entries below the counts are ever read. No stall input.
module arp_binding_inspector
    import abi_pkg::*;
#(
    parameter int TABLE_ENTRIES     = 64,
    parameter int BLACKLIST_ENTRIES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    t_cmd       cmd;
    t_status    status;
    logic [7:0] r_max_changes;

    // Hold the change limit; write whenever a beat arrives.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_changes <= MAX_CHANGES_RESET;
        end else if (i_cfg_valid) begin
            r_max_changes <= i_cfg_data;
        end
    end

    abi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_status(status),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    abi_datapath #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .BLACKLIST_ENTRIES(BLACKLIST_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_max_changes (r_max_changes),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_result      (o_result),
        .o_result_valid(o_done)
    );

    // A result beat appears only in the cycle after the finish step.
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(cmd.finish)) else $error("result without finish");
    // A result never carries both ignored and learned.
    a_ignored_not_learned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.ignored && o_result.learned))
        else $error("ignored item learned");
    // Start while idle always makes the block busy next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
endmodule
